### hdl/smtf_pkg.sv
// Shared types, codes and constants of the sampled memory trace filter.
package smtf_pkg;

  localparam int THREADS  = 8;
  localparam int THREAD_W = (THREADS > 1) ? $clog2(THREADS) : 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam int SEG_W  = 32;
  localparam int STEP_W = $clog2(SEG_W);

  // opcodes of an input item
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // kinds of a result item
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_ROLL  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  localparam logic [4:0] CLASS_PLAIN     = 5'd0;
  localparam logic [4:0] CLASS_ATOMIFIED = 5'd18;

  // register indexes
  localparam logic [2:0] REG_TRACE_ENABLE   = 3'd0;
  localparam logic [2:0] REG_ATOMIFY_ENABLE = 3'd1;
  localparam logic [2:0] REG_PROFILE_LEVEL  = 3'd2;
  localparam logic [2:0] REG_SAMPLE_GAP     = 3'd3;
  localparam logic [2:0] REG_SAMPLE_LENGTH  = 3'd4;
  localparam logic [2:0] REG_SAMPLE_LIMIT   = 3'd5;
  localparam logic [2:0] REG_FILE_TRIP      = 3'd6;
  localparam logic [2:0] REG_ACTIVE_THREADS = 3'd7;

  localparam logic [63:0] WIDE_RESET           = 64'h0004_0000_0000_0000;
  localparam logic [3:0]  ACTIVE_THREADS_RESET = 4'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  thread;
    logic [63:0] address;
    logic [7:0]  access_size;
    logic [4:0]  atomic_class;
  } smtf_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  thread_id;
    logic [63:0] icount;
    logic [63:0] mem_address;
    logic [7:0]  rec_size;
    logic [4:0]  class_out;
    logic [31:0] segment_index;
    logic        last;
  } smtf_result_t;

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_LOAD,
    SW_STEP,
    SW_STORE
  } sweep_state_t;

  // trip mark recompute pass toward the filter core
  typedef struct packed {
    logic                busy;
    logic                wr_en;
    logic [THREAD_W-1:0] idx;
    logic [63:0]         mark;
    logic                ovf;
  } smtf_sweep_t;

endpackage

### hdl/smtf_in_if.sv
// Trace event channel: valid/ready with the event fields.
interface smtf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  thread;
  logic [63:0] address;
  logic [7:0]  access_size;
  logic [4:0]  atomic_class;

  modport source (
    output valid, opcode, thread, address, access_size, atomic_class,
    input  ready
  );
  modport sink (
    input  valid, opcode, thread, address, access_size, atomic_class,
    output ready
  );
endinterface

### hdl/smtf_out_if.sv
// Trace record channel: valid/ready with the record fields.
interface smtf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  thread_id;
  logic [63:0] icount;
  logic [63:0] mem_address;
  logic [7:0]  rec_size;
  logic [4:0]  class_out;
  logic [31:0] segment_index;
  logic        last;

  modport source (
    output valid, kind, thread_id, icount, mem_address, rec_size,
           class_out, segment_index, last,
    input  ready
  );
  modport sink (
    input  valid, kind, thread_id, icount, mem_address, rec_size,
           class_out, segment_index, last,
    output ready
  );
endinterface

### hdl/smtf_trip_sweep.sv
// Recomputes every thread's trip mark (file_trip * segment_next) with a shift-add multiplier.
module smtf_trip_sweep
  import smtf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       file_trip,
  input  logic [SEG_W-1:0]  segment_next [THREADS],
  output smtf_sweep_t       sweep
);

  sweep_state_t        state, state_next;
  logic [THREAD_W-1:0] idx;
  logic [STEP_W-1:0]   step;
  logic [SEG_W-1:0]    mreg;
  logic [95:0]         acc;
  logic [95:0]         acc_next;
  logic                last_thread;

  assign last_thread = (idx == THREAD_W'(THREADS - 1));
  assign acc_next    = {acc[94:0], 1'b0} + (mreg[SEG_W-1] ? {32'b0, file_trip} : 96'b0);

  always_comb begin
    state_next = state;
    priority if (start) begin
      state_next = SW_LOAD;
    end else begin
      unique case (state)
        SW_IDLE:  state_next = SW_IDLE;
        SW_LOAD:  state_next = SW_STEP;
        SW_STEP:  state_next = (step == STEP_W'(SEG_W - 1)) ? SW_STORE : SW_STEP;
        SW_STORE: state_next = last_thread ? SW_IDLE : SW_LOAD;
        default:  state_next = SW_IDLE;
      endcase
    end
  end

  always_comb begin
    sweep.busy  = (state != SW_IDLE);
    sweep.wr_en = (state == SW_STORE);
    sweep.idx   = idx;
    sweep.mark  = acc[63:0];
    sweep.ovf   = |acc[95:64];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SW_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        idx <= '0;
      end else if (state == SW_STORE && !last_thread) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // datapath, MSB first over the segment number
  always_ff @(posedge clk) begin
    if (state == SW_LOAD) begin
      mreg <= segment_next[idx];
      acc  <= '0;
      step <= '0;
    end else if (state == SW_STEP) begin
      mreg <= {mreg[SEG_W-2:0], 1'b0};
      acc  <= acc_next;
      step <= step + 1'b1;
    end
  end

endmodule

### hdl/sampled_memory_trace_filter.sv
// Per-thread sampled memory trace filter: top level.
//
// Events are registered on entry and handled from the input register; one
// event is taken per cycle while the record queue has room for two records
// and no recompute pass runs. Records drain through a four-entry queue, one
// record per output transfer; an instruction tick that yields both an all-done
// and a roll record takes two output transfers. Each thread keeps its next trip
// mark (file_trip * segment_next), advanced by one add per roll. Writing
// file_trip starts a recompute pass over every thread
// through a shared shift-add multiplier; events are not taken during the pass,
// register writes are. Configuration is an APB port with 64-bit registers at
// byte address 8*index.
module sampled_memory_trace_filter
  import smtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  smtf_in_if.sink     events,
  smtf_out_if.source  records,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // configuration
  logic        trace_enable;
  logic        atomify_enable;
  logic [1:0]  profile_level;
  logic [63:0] sample_gap;
  logic [63:0] sample_length;
  logic [63:0] sample_limit;
  logic [63:0] file_trip;
  logic [3:0]  active_threads;

  // per-thread state
  logic [63:0]      inst_count     [THREADS];
  logic [63:0]      window_counter [THREADS];
  logic [63:0]      windows_taken  [THREADS];
  logic [SEG_W-1:0] segment_next   [THREADS];
  logic [63:0]      trip_mark      [THREADS];
  logic [THREADS-1:0] recording;
  logic [THREADS-1:0] thread_done;
  logic [THREADS-1:0] thread_started;
  logic [THREADS-1:0] trip_ovf;

  smtf_sweep_t sweep;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  // input register
  logic       iv;
  smtf_item_t ir;
  logic       proc;

  // record queue
  smtf_result_t            fifo [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   fifo_count;
  logic                    pop;
  logic [1:0]              push_cnt;
  smtf_result_t            res0;
  smtf_result_t            res1;

  // handling of the registered event
  logic [THREAD_W-1:0] tidx;
  logic [7:0]          thr_limit;
  logic                take;
  logic                upd;
  logic [63:0]         ic_next;
  logic [63:0]         wc_next;
  logic [63:0]         wt_next;
  logic                rec_next;
  logic                done_next;
  logic                started_next;
  logic [SEG_W-1:0]    seg_next;
  logic [63:0]         mark_next;
  logic                ovf_next;
  logic [63:0]         ic_inc;
  logic [63:0]         ic_mem;
  logic [64:0]         mark_sum;
  logic                done_hit;
  logic                all_done;
  logic                roll;
  logic [4:0]          cls;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_enable   <= 1'b0;
      atomify_enable <= 1'b0;
      profile_level  <= 2'd0;
      sample_gap     <= '0;
      sample_length  <= WIDE_RESET;
      sample_limit   <= WIDE_RESET;
      file_trip      <= WIDE_RESET;
      active_threads <= ACTIVE_THREADS_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TRACE_ENABLE:   trace_enable   <= pwdata[0];
        REG_ATOMIFY_ENABLE: atomify_enable <= pwdata[0];
        REG_PROFILE_LEVEL:  profile_level  <= pwdata[1:0];
        REG_SAMPLE_GAP:     sample_gap     <= pwdata;
        REG_SAMPLE_LENGTH:  sample_length  <= pwdata;
        REG_SAMPLE_LIMIT:   sample_limit   <= pwdata;
        REG_FILE_TRIP:      file_trip      <= pwdata;
        REG_ACTIVE_THREADS: active_threads <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRACE_ENABLE:   prdata = {63'b0, trace_enable};
      REG_ATOMIFY_ENABLE: prdata = {63'b0, atomify_enable};
      REG_PROFILE_LEVEL:  prdata = {62'b0, profile_level};
      REG_SAMPLE_GAP:     prdata = sample_gap;
      REG_SAMPLE_LENGTH:  prdata = sample_length;
      REG_SAMPLE_LIMIT:   prdata = sample_limit;
      REG_FILE_TRIP:      prdata = file_trip;
      REG_ACTIVE_THREADS: prdata = {60'b0, active_threads};
      default:            prdata = '0;
    endcase
  end

  smtf_trip_sweep u_sweep (
    .clk          (clk),
    .rst          (rst),
    .start        (cfg_wr && reg_idx == REG_FILE_TRIP),
    .file_trip    (file_trip),
    .segment_next (segment_next),
    .sweep        (sweep)
  );

  // leave room for two records before handling an event
  assign proc         = iv && !sweep.busy && (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign events.ready = !sweep.busy && (!iv || proc);

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (events.ready) begin
      iv <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      ir.opcode       <= events.opcode;
      ir.thread       <= events.thread;
      ir.address      <= events.address;
      ir.access_size  <= events.access_size;
      ir.atomic_class <= events.atomic_class;
    end
  end

  assign tidx      = ir.thread[THREAD_W-1:0];
  assign thr_limit = ({4'b0, active_threads} < 8'(THREADS)) ? {4'b0, active_threads}
                                                            : 8'(THREADS);
  assign take      = proc && trace_enable && (ir.opcode != OP_UNUSED) &&
                     (ir.thread < thr_limit);
  assign ic_inc    = inst_count[tidx] + 64'd1;
  assign ic_mem    = thread_started[tidx] ? inst_count[tidx] : inst_count[0];
  assign mark_sum  = {1'b0, trip_mark[tidx]} + {1'b0, file_trip};

  // all active threads done, counting this thread as done
  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < THREADS; i++) begin
      if (8'(i) < thr_limit && !(thread_done[i] || THREAD_W'(i) == tidx)) begin
        all_done = 1'b0;
      end
    end
  end

  always_comb begin
    cls = ir.atomic_class;
    if (atomify_enable && profile_level > 2'd1 && cls == CLASS_PLAIN) begin
      cls = CLASS_ATOMIFIED;
    end
    if (profile_level == 2'd0) begin
      cls = CLASS_PLAIN;
    end
  end

  always_comb begin
    ic_next      = inst_count[tidx];
    wc_next      = window_counter[tidx];
    wt_next      = windows_taken[tidx];
    rec_next     = recording[tidx];
    done_next    = thread_done[tidx];
    started_next = thread_started[tidx];
    seg_next     = segment_next[tidx];
    mark_next    = trip_mark[tidx];
    ovf_next     = trip_ovf[tidx];
    done_hit     = 1'b0;
    roll         = 1'b0;
    upd          = 1'b0;
    push_cnt     = 2'd0;
    res0         = '0;
    res1         = '0;

    if (take) begin
      upd = 1'b1;
      if (ir.opcode == OP_TICK) begin
        ic_next = ic_inc;
        priority if (sample_gap == 64'd0) begin
          rec_next = 1'b1;
        end else if (!recording[tidx]) begin
          priority if (window_counter[tidx] < sample_gap) begin
            wc_next = window_counter[tidx] + 64'd1;
          end else if (windows_taken[tidx] < sample_limit) begin
            rec_next = 1'b1;
            wc_next  = '0;
            wt_next  = windows_taken[tidx] + 64'd1;
          end else begin
            done_next = 1'b1;
            done_hit  = all_done;
          end
        end else begin
          if (window_counter[tidx] < sample_length) begin
            wc_next = window_counter[tidx] + 64'd1;
          end else begin
            rec_next = 1'b0;
            wc_next  = '0;
          end
        end

        roll = !trip_ovf[tidx] && (ic_inc >= trip_mark[tidx]);
        if (roll) begin
          seg_next = segment_next[tidx] + 1'b1;
          // segment number wraps to zero, and so does its product
          if (segment_next[tidx] == '1) begin
            mark_next = '0;
            ovf_next  = 1'b0;
          end else begin
            mark_next = mark_sum[63:0];
            ovf_next  = mark_sum[64];
          end
        end

        if (done_hit) begin
          res0.kind      = KIND_DONE;
          res0.thread_id = ir.thread[2:0];
          res0.icount    = ic_inc;
          res0.last      = !roll;
        end
        if (roll) begin
          res1.kind          = KIND_ROLL;
          res1.thread_id     = ir.thread[2:0];
          res1.icount        = ic_inc;
          res1.segment_index = segment_next[tidx] - 1'b1;
          res1.last          = 1'b1;
        end
        priority if (done_hit && roll) begin
          push_cnt = 2'd2;
        end else if (done_hit) begin
          push_cnt = 2'd1;
        end else if (roll) begin
          push_cnt = 2'd1;
          res0     = res1;
        end else begin
          push_cnt = 2'd0;
        end
      end else if (recording[tidx]) begin
        // first access of a thread picks up thread 0's count
        ic_next          = ic_mem;
        started_next     = 1'b1;
        res0.kind        = (ir.opcode == OP_WRITE) ? KIND_WRITE : KIND_READ;
        res0.thread_id   = ir.thread[2:0];
        res0.icount      = ic_mem;
        res0.mem_address = ir.address;
        res0.rec_size    = ir.access_size;
        res0.class_out   = cls;
        res0.last        = 1'b1;
        push_cnt         = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREADS; i++) begin
        inst_count[i]     <= '0;
        window_counter[i] <= '0;
        windows_taken[i]  <= '0;
        segment_next[i]   <= SEG_W'(1);
        trip_mark[i]      <= WIDE_RESET;
      end
      recording      <= '0;
      thread_done    <= '0;
      thread_started <= THREADS'(1);
      trip_ovf       <= '0;
    end else begin
      if (upd) begin
        inst_count[tidx]     <= ic_next;
        window_counter[tidx] <= wc_next;
        windows_taken[tidx]  <= wt_next;
        segment_next[tidx]   <= seg_next;
        trip_mark[tidx]      <= mark_next;
        recording[tidx]      <= rec_next;
        thread_done[tidx]    <= done_next;
        thread_started[tidx] <= started_next;
        trip_ovf[tidx]       <= ovf_next;
      end else if (sweep.wr_en) begin
        trip_mark[sweep.idx] <= sweep.mark;
        trip_ovf[sweep.idx]  <= sweep.ovf;
      end
    end
  end

  // record queue
  assign pop = records.valid && records.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + FIFO_PTR_W'(push_cnt);
      rd_ptr     <= rd_ptr + FIFO_PTR_W'(pop);
      fifo_count <= fifo_count + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      fifo[wr_ptr] <= res0;
    end
    if (push_cnt == 2'd2) begin
      fifo[wr_ptr + 1'b1] <= res1;
    end
  end

  assign records.valid         = (fifo_count != '0);
  assign records.kind          = fifo[rd_ptr].kind;
  assign records.thread_id     = fifo[rd_ptr].thread_id;
  assign records.icount        = fifo[rd_ptr].icount;
  assign records.mem_address   = fifo[rd_ptr].mem_address;
  assign records.rec_size      = fifo[rd_ptr].rec_size;
  assign records.class_out     = fifo[rd_ptr].class_out;
  assign records.segment_index = fifo[rd_ptr].segment_index;
  assign records.last          = fifo[rd_ptr].last;

endmodule

### sim/sampled_memory_trace_filter_tb.sv
// Self-checking testbench of the sampled memory trace filter.
`timescale 1ns / 100ps

module sampled_memory_trace_filter_tb;
  import smtf_pkg::*;

  localparam logic [63:0] ALL_ONES = '1;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  smtf_in_if  ev_if ();
  smtf_out_if rec_if ();

  sampled_memory_trace_filter u_dut (
    .clk     (clk),
    .rst     (rst),
    .events  (ev_if),
    .records (rec_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register shadow
  logic        cfg_trace;
  logic        cfg_atomify;
  logic [1:0]  cfg_profile;
  logic [63:0] cfg_gap;
  logic [63:0] cfg_length;
  logic [63:0] cfg_limit;
  logic [63:0] cfg_trip;
  logic [3:0]  cfg_threads;

  // per-thread filter state
  logic [63:0] inst_cnt    [THREADS];
  logic [63:0] win_cnt     [THREADS];
  logic        in_window   [THREADS];
  logic [63:0] win_taken   [THREADS];
  logic        thr_done    [THREADS];
  logic        thr_started [THREADS];
  logic [31:0] seg_next    [THREADS];

  smtf_item_t   event_queue [$];
  smtf_result_t expected_records [$];
  smtf_item_t   drive_item;

  logic ev_taken;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_req;
  int   hold_ack;
  int   hold_left;
  int   error_count;
  int   events_taken;
  int   records_checked;
  int   settings_applied;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int thread_span();
    int n;
    n = (cfg_threads < THREADS) ? cfg_threads : THREADS;
    return n;
  endfunction

  task automatic filter_reset();
    int i;
    cfg_trace   = 1'b0;
    cfg_atomify = 1'b0;
    cfg_profile = 2'd0;
    cfg_gap     = 64'd0;
    cfg_length  = WIDE_RESET;
    cfg_limit   = WIDE_RESET;
    cfg_trip    = WIDE_RESET;
    cfg_threads = ACTIVE_THREADS_RESET;
    for (i = 0; i < THREADS; i++) begin
      inst_cnt[i]    = 64'd0;
      win_cnt[i]     = 64'd0;
      in_window[i]   = 1'b0;
      win_taken[i]   = 64'd0;
      thr_done[i]    = 1'b0;
      thr_started[i] = (i == 0);
      seg_next[i]    = 32'd1;
    end
  endtask

  function automatic smtf_result_t make_record(logic [1:0] kind, int t, logic [63:0] cnt,
                                               logic [63:0] addr, logic [7:0] size,
                                               logic [4:0] cls, logic [31:0] seg);
    smtf_result_t r;
    r.kind          = kind;
    r.thread_id     = t[2:0];
    r.icount        = cnt;
    r.mem_address   = addr;
    r.rec_size      = size;
    r.class_out     = cls;
    r.segment_index = seg;
    r.last          = 1'b0;
    return r;
  endfunction

  // Works out the records one accepted event gives and queues them.
  task automatic filter_event(smtf_item_t it);
    smtf_result_t batch [$];
    int           t;
    int           span;
    int           ndone;
    int           i;
    logic [4:0]   cls;
    logic [127:0] mark;
    span = thread_span();
    if (!cfg_trace || it.opcode == OP_UNUSED || it.thread >= span) return;
    t = it.thread;
    if (it.opcode == OP_TICK) begin
      inst_cnt[t] = inst_cnt[t] + 64'd1;
      if (cfg_gap == 64'd0) begin
        in_window[t] = 1'b1;
      end else if (!in_window[t]) begin
        if (win_cnt[t] < cfg_gap) begin
          win_cnt[t] = win_cnt[t] + 64'd1;
        end else if (win_taken[t] < cfg_limit) begin
          in_window[t] = 1'b1;
          win_cnt[t]   = 64'd0;
          win_taken[t] = win_taken[t] + 64'd1;
        end else begin
          thr_done[t] = 1'b1;
          ndone = 0;
          for (i = 0; i < span; i++) if (thr_done[i]) ndone++;
          if (ndone == span)
            batch.push_back(make_record(KIND_DONE, t, inst_cnt[t], 64'd0, 8'd0, CLASS_PLAIN,
                                        32'd0));
        end
      end else begin
        if (win_cnt[t] < cfg_length) begin
          win_cnt[t] = win_cnt[t] + 64'd1;
        end else begin
          in_window[t] = 1'b0;
          win_cnt[t]   = 64'd0;
        end
      end
      // a mark past 64 bits never trips
      mark = {64'd0, cfg_trip} * {96'd0, seg_next[t]};
      if (mark[127:64] == 64'd0 && inst_cnt[t] >= mark[63:0]) begin
        batch.push_back(make_record(KIND_ROLL, t, inst_cnt[t], 64'd0, 8'd0, CLASS_PLAIN,
                                    seg_next[t] - 32'd1));
        seg_next[t] = seg_next[t] + 32'd1;
      end
    end else begin
      if (!in_window[t]) return;
      if (!thr_started[t]) begin
        inst_cnt[t]    = inst_cnt[0];
        thr_started[t] = 1'b1;
      end
      cls = it.atomic_class;
      if (cfg_atomify && cfg_profile > 2'd1 && cls == CLASS_PLAIN) cls = CLASS_ATOMIFIED;
      if (cfg_profile == 2'd0) cls = CLASS_PLAIN;
      batch.push_back(make_record((it.opcode == OP_READ) ? KIND_READ : KIND_WRITE, t,
                                  inst_cnt[t], it.address, it.access_size, cls, 32'd0));
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    for (i = 0; i < batch.size(); i++) expected_records.push_back(batch[i]);
  endtask

  task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
    $display("time %0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    error_count++;
  endtask

  task automatic check_record();
    smtf_result_t got;
    smtf_result_t want;
    got.kind          = rec_if.kind;
    got.thread_id     = rec_if.thread_id;
    got.icount        = rec_if.icount;
    got.mem_address   = rec_if.mem_address;
    got.rec_size      = rec_if.rec_size;
    got.class_out     = rec_if.class_out;
    got.segment_index = rec_if.segment_index;
    got.last          = rec_if.last;
    if (expected_records.size() == 0) begin
      $display("time %0t: unexpected record, expected none, got kind %0d thread %0d",
               $time, got.kind, got.thread_id);
      error_count++;
      return;
    end
    want = expected_records.pop_front();
    records_checked++;
    if (got.kind !== want.kind) report_field("kind", want.kind, got.kind);
    if (got.thread_id !== want.thread_id) report_field("thread_id", want.thread_id, got.thread_id);
    if (got.icount !== want.icount) report_field("icount", want.icount, got.icount);
    if (got.mem_address !== want.mem_address)
      report_field("mem_address", want.mem_address, got.mem_address);
    if (got.rec_size !== want.rec_size) report_field("rec_size", want.rec_size, got.rec_size);
    if (got.class_out !== want.class_out) report_field("class_out", want.class_out, got.class_out);
    if (got.segment_index !== want.segment_index)
      report_field("segment_index", want.segment_index, got.segment_index);
    if (got.last !== want.last) report_field("last", want.last, got.last);
  endtask

  // event driver
  always @(negedge clk) begin
    if (!rst && (!ev_if.valid || ev_taken)) begin
      if (event_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item = event_queue.pop_front();
        ev_if.valid        <= 1'b1;
        ev_if.opcode       <= drive_item.opcode;
        ev_if.thread       <= drive_item.thread;
        ev_if.address      <= drive_item.address;
        ev_if.access_size  <= drive_item.access_size;
        ev_if.atomic_class <= drive_item.atomic_class;
      end else begin
        ev_if.valid <= 1'b0;
      end
    end
  end

  // record receiver; a hold request forces a long stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rec_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= 150;
      rec_if.ready <= 1'b0;
    end else begin
      rec_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on each event transfer, check each record transfer
  always @(posedge clk) begin
    if (rst) begin
      ev_taken <= 1'b0;
    end else begin
      ev_taken <= ev_if.valid && ev_if.ready;
      if (ev_if.valid && ev_if.ready) begin
        filter_event(drive_item);
        events_taken++;
      end
      if (rec_if.valid && rec_if.ready) check_record();
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TRACE_ENABLE:   cfg_trace   = value[0];
      REG_ATOMIFY_ENABLE: cfg_atomify = value[0];
      REG_PROFILE_LEVEL:  cfg_profile = value[1:0];
      REG_SAMPLE_GAP:     cfg_gap     = value;
      REG_SAMPLE_LENGTH:  cfg_length  = value;
      REG_SAMPLE_LIMIT:   cfg_limit   = value;
      REG_FILE_TRIP:      cfg_trip    = value;
      REG_ACTIVE_THREADS: cfg_threads = value[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic en, logic atom, logic [1:0] prof, logic [63:0] gap,
                                logic [63:0] len, logic [63:0] lim, logic [63:0] trip,
                                logic [3:0] nthr);
    reg_write(REG_TRACE_ENABLE, {63'd0, en});
    reg_write(REG_ATOMIFY_ENABLE, {63'd0, atom});
    reg_write(REG_PROFILE_LEVEL, {62'd0, prof});
    reg_write(REG_SAMPLE_GAP, gap);
    reg_write(REG_SAMPLE_LENGTH, len);
    reg_write(REG_SAMPLE_LIMIT, lim);
    reg_write(REG_FILE_TRIP, trip);
    reg_write(REG_ACTIVE_THREADS, {60'd0, nthr});
    settings_applied++;
  endtask

  // all events taken, all records seen, then a margin for events with no record
  task automatic wait_idle();
    while (event_queue.size() != 0 || ev_if.valid || expected_records.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic smtf_item_t mk_event(logic [1:0] op, logic [7:0] thr, logic [63:0] addr,
                                          logic [7:0] size, logic [4:0] cls);
    smtf_item_t it;
    it.opcode       = op;
    it.thread       = thr;
    it.address      = addr;
    it.access_size  = size;
    it.atomic_class = cls;
    return it;
  endfunction

  task automatic run_random(int count);
    smtf_item_t it;
    int         span;
    int         sel;
    int         k;
    span = thread_span();
    if (span == 0) span = 1;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 45) it.opcode = OP_TICK;
      else if (sel < 70) it.opcode = OP_READ;
      else if (sel < 96) it.opcode = OP_WRITE;
      else it.opcode = OP_UNUSED;
      sel = $urandom_range(99);
      if (sel < 85) it.thread = $urandom_range(span - 1);
      else if (sel < 92) it.thread = span;
      else it.thread = $urandom_range(255);
      sel = $urandom_range(99);
      if (sel < 4) it.address = 64'd0;
      else if (sel < 8) it.address = ALL_ONES;
      else it.address = {$urandom, $urandom};
      it.access_size = $urandom_range(255);
      sel = $urandom_range(99);
      if (sel < 45) it.atomic_class = CLASS_PLAIN;
      else if (sel < 80) it.atomic_class = $urandom_range(17, 1);
      else if (sel < 90) it.atomic_class = CLASS_ATOMIFIED;
      else it.atomic_class = $urandom_range(31, 19);
      event_queue.push_back(it);
    end
    wait_idle();
  endtask

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    ev_if.valid         = 1'b0;
    ev_if.opcode        = OP_TICK;
    ev_if.thread        = '0;
    ev_if.address       = '0;
    ev_if.access_size   = '0;
    ev_if.atomic_class  = CLASS_PLAIN;
    rec_if.ready        = 1'b0;
    ev_taken            = 1'b0;
    send_idle_pct       = 0;
    recv_idle_pct       = 0;
    hold_req            = 0;
    hold_ack            = 0;
    hold_left           = 0;
    error_count         = 0;
    events_taken        = 0;
    records_checked     = 0;
    settings_applied    = 0;
    filter_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // tracing is off out of reset: dropped
    event_queue.push_back(mk_event(OP_TICK, 8'd0, 64'd0, 8'd0, CLASS_PLAIN));
    event_queue.push_back(mk_event(OP_READ, 8'd0, 64'd0, 8'd0, CLASS_PLAIN));
    wait_idle();

    // always recording, roll every fourth tick
    apply_settings(1'b1, 1'b1, 2'd3, 64'd0, ALL_ONES, ALL_ONES, 64'd4, 4'd8);
    repeat (4) event_queue.push_back(mk_event(OP_TICK, 8'd0, 64'd0, 8'd0, CLASS_PLAIN));
    event_queue.push_back(mk_event(OP_TICK, 8'd1, 64'd0, 8'd0, CLASS_PLAIN));
    // first access of thread 1 takes thread 0's count
    event_queue.push_back(mk_event(OP_READ, 8'd1, 64'd0, 8'd0, CLASS_PLAIN));
    event_queue.push_back(mk_event(OP_WRITE, 8'd1, ALL_ONES, 8'hff, 5'd31));
    event_queue.push_back(mk_event(OP_READ, 8'd0, 64'h8000_0000_0000_0000, 8'd1, 5'd17));
    event_queue.push_back(mk_event(OP_WRITE, 8'd0, 64'h0123_4567_89ab_cdef, 8'd8,
                                   CLASS_ATOMIFIED));
    event_queue.push_back(mk_event(OP_UNUSED, 8'd0, 64'd0, 8'd0, CLASS_PLAIN));
    event_queue.push_back(mk_event(OP_TICK, 8'd255, 64'd0, 8'd0, CLASS_PLAIN));
    event_queue.push_back(mk_event(OP_READ, 8'd8, 64'd0, 8'd0, CLASS_PLAIN));
    event_queue.push_back(mk_event(OP_READ, 8'd2, 64'd5, 8'd4, CLASS_PLAIN));
    event_queue.push_back(mk_event(OP_WRITE, 8'd3, 64'd6, 8'd4, 5'd16));
    event_queue.push_back(mk_event(OP_TICK, 8'd2, 64'd0, 8'd0, CLASS_PLAIN));
    event_queue.push_back(mk_event(OP_WRITE, 8'd2, 64'd7, 8'd2, CLASS_PLAIN));
    wait_idle();

    // one short window, then done; done and roll land on the same tick
    apply_settings(1'b1, 1'b0, 2'd2, 64'd1, 64'd0, 64'd1, 64'd1, 4'd1);
    repeat (3) event_queue.push_back(mk_event(OP_TICK, 8'd0, 64'd0, 8'd0, CLASS_PLAIN));
    event_queue.push_back(mk_event(OP_READ, 8'd0, 64'd9, 8'd3, CLASS_PLAIN));
    repeat (4) event_queue.push_back(mk_event(OP_TICK, 8'd0, 64'd0, 8'd0, CLASS_PLAIN));
    wait_idle();

    send_idle_pct = 38;
    recv_idle_pct = 50;
    apply_settings(1'b1, 1'b1, 2'd3, 64'd0, ALL_ONES, ALL_ONES, 64'd7, 4'd8);
    hold_req++;
    run_random(240);
    apply_settings(1'b1, 1'b0, 2'd2, 64'd2, 64'd3, ALL_ONES, 64'd5, 4'd4);
    run_random(240);
    apply_settings(1'b1, 1'b1, 2'd1, 64'd1, 64'd1, 64'd2, 64'd1, 4'd2);
    run_random(240);

    send_idle_pct = 50;
    recv_idle_pct = 38;
    apply_settings(1'b1, 1'b1, 2'd0, 64'd3, 64'd0, 64'd0, 64'd3, 4'd1);
    run_random(220);
    // huge trip marks overflow, widest gap never opens a window
    apply_settings(1'b1, 1'b0, 2'd3, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 4'd15);
    run_random(220);
    apply_settings(1'b1, 1'b1, 2'd2, 64'd0, 64'd2, 64'd3, 64'h8000_0000_0000_0000, 4'd0);
    run_random(40);
    apply_settings(1'b0, 1'b1, 2'd2, 64'd0, 64'd2, 64'd3, 64'd2, 4'd8);
    run_random(40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(1'b1, 1'b1, 2'd2, 64'd1, 64'd2, 64'd3, 64'd4, 4'd8);
    run_random(240);
    apply_settings(1'b1, 1'b0, 2'd3, 64'd0, 64'd5, 64'd1, 64'd9, 4'd3);
    run_random(240);
    apply_settings(1'b1, 1'b1, 2'd3, 64'd2, 64'd4, ALL_ONES, 64'd6, 4'd8);
    run_random(240);

    $display("%0d events taken under %0d register settings, %0d records checked",
             events_taken, settings_applied, records_checked);
    $display("covered sampling windows, segment rolls, all-done events and class rules");
    if (error_count == 0 && expected_records.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
